// ===== rtl/lcd_mode_sequencer_with_sprite_scan_assert.svh =====
`ifndef LCD_MODE_SEQUENCER_WITH_SPRITE_SCAN_ASSERT_SVH
`define LCD_MODE_SEQUENCER_WITH_SPRITE_SCAN_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define LMSS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define LMSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lmss_pkg.sv =====
package lmss_pkg;

    localparam int OAM_ENTRIES      = 40;
    localparam int MAX_LINE_SPRITES = 10;
    localparam int VRAM_BYTES       = 8192;

    localparam int VRAM_AW    = $clog2(VRAM_BYTES);
    localparam int OBJ_BYTES  = 160;
    localparam int OAM_WORDS  = OBJ_BYTES / 4;
    localparam int OAM_WAW    = $clog2(OAM_WORDS);
    localparam int SPRITE_CAP = (MAX_LINE_SPRITES < 15) ? MAX_LINE_SPRITES : 15;

    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_READ    = 2'd1,
        OP_WRITE   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM_SCAN = 2'd2,
        MODE_DRAW     = 2'd3
    } mode_t;

    localparam logic [13:0] LEN_OAM_SCAN = 14'd80;
    localparam logic [13:0] LEN_DRAW     = 14'd172;
    localparam logic [13:0] LEN_HBLANK   = 14'd376;
    localparam logic [13:0] LEN_VBLANK   = 14'd4560;

    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [7:0] UNMAPPED_BYTE     = 8'hFF;
    localparam logic [7:0] LCD_STATUS_VALUE  = 8'h00;

    localparam logic [15:0] ADDR_LCD_CONTROL = 16'hFF40;
    localparam logic [15:0] ADDR_LCD_STATUS  = 16'hFF41;
    localparam logic [15:0] ADDR_SCROLL_Y    = 16'hFF42;
    localparam logic [15:0] ADDR_SCROLL_X    = 16'hFF43;
    localparam logic [15:0] ADDR_LINE        = 16'hFF44;
    localparam logic [15:0] ADDR_LINE_CMP    = 16'hFF45;
    localparam logic [15:0] ADDR_PALETTE_0   = 16'hFF47;
    localparam logic [15:0] ADDR_PALETTE_1   = 16'hFF48;
    localparam logic [15:0] ADDR_PALETTE_2   = 16'hFF49;
    localparam logic [15:0] ADDR_WINDOW_Y    = 16'hFF4A;
    localparam logic [15:0] ADDR_WINDOW_X    = 16'hFF4B;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic take;
        logic exec;
        logic scan;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_req;
        logic scan_more;
        logic scan_pend;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/lmss_ctrl.sv =====
module lmss_ctrl
    import lmss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.scan_req ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                // leave once nothing is left to fetch; the last fetched entry
                // is compared in this same cycle
                if (!sts.scan_more) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lmss_dp.sv =====
module lmss_dp
    import lmss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  s_tuser,
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    input  cmd_t        cmd,
    output sts_t        sts
);

    // item holding registers
    logic [1:0]  op_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wdata_reg;
    logic [7:0]  cycles_reg;

    // programmable registers
    logic [7:0] lcd_control_reg, lcd_control_next;
    logic [7:0] scroll_y_reg, scroll_y_next;
    logic [7:0] scroll_x_reg, scroll_x_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] line_cmp_reg, line_cmp_next;
    logic [7:0] palette_reg [3];
    logic [7:0] palette_next [3];
    logic [7:0] window_reg [2];
    logic [7:0] window_next [2];

    // mode sequencer and scan state
    mode_t       mode_reg, mode_next;
    logic [12:0] elapsed_reg, elapsed_next;
    logic [6:0]  scan_pos_reg, scan_pos_next;
    logic [6:0]  scan_lim_reg, scan_lim_next;
    logic [3:0]  count_reg, count_next;
    logic        pend_reg, pend_next;
    logic        oob_reg, oob_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg;

    // memories
    logic [7:0]  vram_mem [VRAM_BYTES];
    logic [31:0] oam_mem [OAM_WORDS];
    logic [7:0]  vram_q;
    logic [31:0] oam_q;

    // decode of the held item
    logic               in_vram, vram_ok, in_oam;
    logic [VRAM_AW-1:0] vram_idx;
    logic [OAM_WAW-1:0] oam_idx;
    logic               oam_re, oam_we, vram_re, vram_we;
    logic               is_adv, is_wr, is_rd;

    // advance arithmetic
    logic [13:0] total;
    logic [13:0] capped;
    logic [6:0]  lim_calc;

    // sprite compare
    logic [7:0] spr_y;
    logic [8:0] line_plus;
    logic [9:0] y_end;
    logic       covers;

    logic [7:0] reg_rd;
    logic [7:0] rdata;

    assign is_adv = (op_reg == OP_ADVANCE);
    assign is_rd  = (op_reg == OP_READ);
    assign is_wr  = (op_reg == OP_WRITE);

    assign in_vram  = (addr_reg[15:13] == 3'b100);
    assign vram_ok  = ({2'b00, addr_reg[12:0]} < 15'(VRAM_BYTES));
    assign vram_idx = VRAM_AW'({1'b0, addr_reg[12:0]});
    assign in_oam   = (addr_reg[15:8] == 8'hFE) && (addr_reg[7:0] < 8'(OBJ_BYTES));

    assign vram_re = cmd.exec && is_rd && in_vram && vram_ok;
    assign vram_we = cmd.exec && is_wr && in_vram && vram_ok;
    assign oam_we  = cmd.exec && is_wr && in_oam;
    assign oam_re  = (cmd.exec && is_rd && in_oam) ||
                     (cmd.scan && sts.scan_more && (scan_pos_reg < 7'(OAM_WORDS)));
    assign oam_idx = cmd.exec ? OAM_WAW'(addr_reg[7:2]) : OAM_WAW'(scan_pos_reg);

    always_ff @(posedge aclk) begin
        if (vram_we) begin
            vram_mem[vram_idx] <= wdata_reg;
        end
        if (vram_re) begin
            vram_q <= vram_mem[vram_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (oam_we) begin
            oam_mem[oam_idx][8*addr_reg[1:0] +: 8] <= wdata_reg;
        end
        if (oam_re) begin
            oam_q <= oam_mem[oam_idx];
        end
    end

    // mode counter
    assign total    = {1'b0, elapsed_reg} + {6'd0, cycles_reg};
    assign capped   = (total >= LEN_OAM_SCAN) ? LEN_OAM_SCAN : total;
    assign lim_calc = (capped[7:1] > 7'(OAM_ENTRIES)) ? 7'(OAM_ENTRIES) : capped[7:1];

    // entries past the object store read as zero
    assign spr_y     = oob_reg ? 8'h00 : oam_q[7:0];
    assign line_plus = {1'b0, line_reg} + 9'd16;
    assign y_end     = {2'b00, spr_y} + (lcd_control_reg[2] ? 10'd16 : 10'd8);
    assign covers    = (line_plus >= {1'b0, spr_y}) && ({1'b0, line_plus} < y_end);

    assign sts.scan_req  = is_adv && (mode_reg == MODE_OAM_SCAN);
    assign sts.scan_more = (scan_pos_reg < scan_lim_reg) && (scan_pos_reg < 7'd64);
    assign sts.scan_pend = pend_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        lcd_control_next = lcd_control_reg;
        scroll_y_next    = scroll_y_reg;
        scroll_x_next    = scroll_x_reg;
        line_next        = line_reg;
        line_cmp_next    = line_cmp_reg;
        palette_next     = palette_reg;
        window_next      = window_reg;
        mode_next        = mode_reg;
        elapsed_next     = elapsed_reg;
        scan_pos_next    = scan_pos_reg;
        scan_lim_next    = scan_lim_reg;
        count_next       = count_reg;
        pend_next        = pend_reg;
        oob_next         = oob_reg;

        if (cmd.exec && is_wr) begin
            case (addr_reg)
                ADDR_LCD_CONTROL: lcd_control_next = wdata_reg;
                ADDR_SCROLL_Y:    scroll_y_next    = wdata_reg;
                ADDR_SCROLL_X:    scroll_x_next    = wdata_reg;
                ADDR_LINE:        line_next        = wdata_reg;
                ADDR_LINE_CMP:    line_cmp_next    = wdata_reg;
                ADDR_PALETTE_0:   palette_next[0]  = wdata_reg;
                ADDR_PALETTE_1:   palette_next[1]  = wdata_reg;
                ADDR_PALETTE_2:   palette_next[2]  = wdata_reg;
                ADDR_WINDOW_Y:    window_next[0]   = wdata_reg;
                ADDR_WINDOW_X:    window_next[1]   = wdata_reg;
                default: ;
            endcase
        end

        if (cmd.exec && is_adv) begin
            elapsed_next = total[12:0];
            case (mode_reg)
                MODE_OAM_SCAN: begin
                    scan_lim_next = lim_calc;
                    if (total >= LEN_OAM_SCAN) begin
                        mode_next    = MODE_DRAW;
                        elapsed_next = 13'(total - LEN_OAM_SCAN);
                    end
                end
                MODE_DRAW: begin
                    if (total >= LEN_DRAW) begin
                        mode_next    = MODE_HBLANK;
                        elapsed_next = 13'(total - LEN_DRAW);
                    end
                end
                MODE_HBLANK: begin
                    if (total >= LEN_HBLANK) begin
                        elapsed_next = 13'(total - LEN_HBLANK);
                        if (line_reg >= FIRST_VBLANK_LINE) begin
                            mode_next = MODE_VBLANK;
                        end else begin
                            mode_next     = MODE_OAM_SCAN;
                            scan_pos_next = '0;
                            count_next    = '0;
                        end
                    end
                end
                default: begin
                    if (total >= LEN_VBLANK) begin
                        elapsed_next  = 13'(total - LEN_VBLANK);
                        mode_next     = MODE_OAM_SCAN;
                        scan_pos_next = '0;
                        count_next    = '0;
                    end
                end
            endcase
        end

        if (cmd.scan) begin
            pend_next = sts.scan_more;
            oob_next  = (scan_pos_reg >= 7'(OAM_WORDS));
            if (sts.scan_more) begin
                scan_pos_next = scan_pos_reg + 7'd1;
            end
            // compare the entry fetched last cycle
            if (pend_reg && covers && (count_reg < 4'(SPRITE_CAP))) begin
                count_next = count_reg + 4'd1;
            end
        end
    end

    always_comb begin
        case (addr_reg)
            ADDR_LCD_CONTROL: reg_rd = lcd_control_reg;
            ADDR_LCD_STATUS:  reg_rd = LCD_STATUS_VALUE;
            ADDR_SCROLL_Y:    reg_rd = scroll_y_reg;
            ADDR_SCROLL_X:    reg_rd = scroll_x_reg;
            ADDR_LINE:        reg_rd = line_reg;
            ADDR_LINE_CMP:    reg_rd = line_cmp_reg;
            ADDR_PALETTE_0:   reg_rd = palette_reg[0];
            ADDR_PALETTE_1:   reg_rd = palette_reg[1];
            ADDR_PALETTE_2:   reg_rd = palette_reg[2];
            ADDR_WINDOW_Y:    reg_rd = window_reg[0];
            ADDR_WINDOW_X:    reg_rd = window_reg[1];
            default:          reg_rd = UNMAPPED_BYTE;
        endcase
    end

    always_comb begin
        if (!is_rd) begin
            rdata = 8'h00;
        end else if (in_vram) begin
            rdata = vram_ok ? vram_q : UNMAPPED_BYTE;
        end else if (in_oam) begin
            rdata = oam_q[8*addr_reg[1:0] +: 8];
        end else begin
            rdata = reg_rd;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg     <= s_tuser;
            addr_reg   <= s_tdata[15:0];
            wdata_reg  <= s_tdata[23:16];
            cycles_reg <= s_tdata[31:24];
        end
        if (cmd.emit) begin
            m_tdata_reg <= {2'b00, count_next, mode_reg, rdata};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcd_control_reg <= '0;
            scroll_y_reg    <= '0;
            scroll_x_reg    <= '0;
            line_reg        <= '0;
            line_cmp_reg    <= '0;
            palette_reg     <= '{default: '0};
            window_reg      <= '{default: '0};
            mode_reg        <= MODE_OAM_SCAN;
            elapsed_reg     <= '0;
            scan_pos_reg    <= '0;
            scan_lim_reg    <= '0;
            count_reg       <= '0;
            pend_reg        <= 1'b0;
            oob_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            lcd_control_reg <= lcd_control_next;
            scroll_y_reg    <= scroll_y_next;
            scroll_x_reg    <= scroll_x_next;
            line_reg        <= line_next;
            line_cmp_reg    <= line_cmp_next;
            palette_reg     <= palette_next;
            window_reg      <= window_next;
            mode_reg        <= mode_next;
            elapsed_reg     <= elapsed_next;
            scan_pos_reg    <= scan_pos_next;
            scan_lim_reg    <= scan_lim_next;
            count_reg       <= count_next;
            pend_reg        <= pend_next;
            oob_reg         <= oob_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/lcd_mode_sequencer_with_sprite_scan.sv =====
// LCD mode sequencer with object scan.
// Input channel s_*: one item per transfer. s_tuser carries the operation
// (advance time, bus read, bus write, or none); s_tdata carries address, write byte
// and cycle count. Result channel m_*: exactly one result per item, holding
// the read byte, the display mode after the item and the number of sprites
// selected for the current line.
// Items are handled one at a time. A bus read, a bus write, or an advance
// outside the object scan mode goes from accept through an execute state to
// the result state. An advance while in object scan fetches one object entry
// per cycle from the object memory port and compares it in the cycle after;
// the entries scanned by that item number at most 40.
// The result sits in an output register; if the receiver stalls, the block
// still takes the next item, finishes it and waits in the result state with
// s_tready low until the earlier result is taken, then accepts the next item.
// Reset (aresetn low at a clock edge) clears all display registers, puts
// the sequencer in object scan mode with zero elapsed cycles and no sprites,
// and drops m_tvalid. Video and object memory keep whatever they held.
module lcd_mode_sequencer_with_sprite_scan
    import lmss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // addr[15:0], wdata[23:16], cycles[31:24]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // rdata[7:0], mode[9:8], sprite_count[13:10], zero
);

`include "lcd_mode_sequencer_with_sprite_scan_assert.svh"

    cmd_t cmd;
    sts_t sts;

    lmss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lmss_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

    `LMSS_ASSERT_IMPL(a_count_cap, m_tvalid, m_tdata[13:10] <= 4'(SPRITE_CAP), "sprite count above cap")
    `LMSS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
    `LMSS_ASSERT_IMPL(a_pend_drain, sts.scan_pend, cmd.scan, "fetched entry left uncompared")

endmodule
